### hw/rtl/lowest_free_room_allocator_macros.svh
// Assertion macros for the lowest free room allocator.
// Expects clk and rst_n in the scope of each use.
`ifndef LOWEST_FREE_ROOM_ALLOCATOR_MACROS_SVH
`define LOWEST_FREE_ROOM_ALLOCATOR_MACROS_SVH

// Same-cycle implication.
`define LFRA_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LFRA_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/lfra_pkg.sv
// Shared constants, codes and the controller command type of the room allocator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package lfra_pkg;

  localparam int NUM_ROOMS     = 256;
  localparam int NUM_CUSTOMERS = 1024;

  localparam int OP_W    = 1;
  localparam int CUST_W  = 10;
  localparam int ROOM_W  = 9;
  localparam int COUNT_W = 9;

  localparam int CUST_IDX_W = $clog2(NUM_CUSTOMERS);

  localparam int WORD_W      = 16;
  localparam int BIT_W       = $clog2(WORD_W);
  localparam int NUM_WORDS   = (NUM_ROOMS + WORD_W - 1) / WORD_W;
  localparam int WORD_IDX_W  = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int IDX_W       = WORD_IDX_W + BIT_W;

  localparam logic [OP_W-1:0] OP_ARRIVE = 1'b0;
  localparam logic [OP_W-1:0] OP_DEPART = 1'b1;

  typedef struct packed {
    logic accept;
    logic apply;
  } lfra_cmd_t;

endpackage
`default_nettype wire

### hw/rtl/lowest_free_room_allocator.sv
// Top level of the lowest free room allocator: sequencer plus datapath.
// Depends on lfra_pkg, lfra_ctrl, lfra_dpath and the assertion macro header.
//
//   channel  handshake             payload
//   in       in_valid / in_stall   in_operation, in_customer_id
//   out      out_valid / out_stall out_room_number, out_no_room, out_current_count,
//                                  out_peak_count
//
// Each transaction has a lookup step that reads the customer table and picks the
// first bitmap word with a free room, then an apply step that encodes within that
// word and updates bitmap, table and counters.
// Synchronous active-low reset clears the bitmap, counters and handshake at once.
// A full result register lets a new transaction enter while out_stall holds a result;
// the apply cycle waits until that register is free.
`timescale 1ns / 1ps
`default_nettype none
`include "lowest_free_room_allocator_macros.svh"
module lowest_free_room_allocator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [lfra_pkg::OP_W-1:0]     in_operation,
  input  logic [lfra_pkg::CUST_W-1:0]   in_customer_id,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lfra_pkg::ROOM_W-1:0]   out_room_number,
  output logic                          out_no_room,
  output logic [lfra_pkg::COUNT_W-1:0]  out_current_count,
  output logic [lfra_pkg::COUNT_W-1:0]  out_peak_count
);
  import lfra_pkg::*;

  lfra_cmd_t cmd;

  lfra_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  lfra_dpath u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_operation      (in_operation),
    .in_customer_id    (in_customer_id),
    .out_room_number   (out_room_number),
    .out_no_room       (out_no_room),
    .out_current_count (out_current_count),
    .out_peak_count    (out_peak_count)
  );

  `LFRA_ASSERT_NEXT(a_one_in_flight, cmd.accept, !cmd.accept && !in_stall == 1'b0, "accept twice in a row")
  `LFRA_ASSERT_IMPL(a_full_no_room, out_valid && out_no_room, out_room_number == '0, "no_room with a room")
  `LFRA_ASSERT_IMPL(a_full_count, out_valid && out_no_room, out_current_count == COUNT_W'(NUM_ROOMS), "no_room below capacity")
  `LFRA_ASSERT_IMPL(a_peak_bound, out_valid, out_current_count <= out_peak_count, "occupancy above peak")

endmodule
`default_nettype wire

### hw/rtl/lfra_ctrl.sv
// Sequencer of the room allocator: lookup and apply steps, output handshake.
// Depends on lfra_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lfra_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  output lfra_pkg::lfra_cmd_t cmd
);
  import lfra_pkg::*;

  localparam logic ST_LOOK  = 1'b0;
  localparam logic ST_APPLY = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;

  assign out_free   = !out_valid_r || !out_stall;
  assign cmd.accept = (state_r == ST_LOOK) && in_valid;
  assign cmd.apply  = (state_r == ST_APPLY) && out_free;
  assign in_stall   = (state_r != ST_LOOK);
  assign out_valid  = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOOK:  if (cmd.accept) state_nxt = ST_APPLY;
      ST_APPLY: if (cmd.apply) state_nxt = ST_LOOK;
      default:  state_nxt = ST_LOOK;
    endcase
  end

  always_comb begin
    priority if (cmd.apply) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOOK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/lfra_dpath.sv
// Datapath of the room allocator: two-level occupancy bitmap, customer table,
// counters and result register. Depends on lfra_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lfra_dpath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lfra_pkg::lfra_cmd_t           cmd,
  input  logic [lfra_pkg::OP_W-1:0]     in_operation,
  input  logic [lfra_pkg::CUST_W-1:0]   in_customer_id,
  output logic [lfra_pkg::ROOM_W-1:0]   out_room_number,
  output logic                          out_no_room,
  output logic [lfra_pkg::COUNT_W-1:0]  out_current_count,
  output logic [lfra_pkg::COUNT_W-1:0]  out_peak_count
);
  import lfra_pkg::*;

  typedef struct packed {
    logic             found;
    logic [BIT_W-1:0] idx;
  } bit_pick_t;

  typedef struct packed {
    logic                  found;
    logic [WORD_IDX_W-1:0] idx;
  } word_pick_t;

  function automatic bit_pick_t pick_bit(input logic [WORD_W-1:0] v);
    bit_pick_t p;
    p = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!v[i]) begin
        p.found = 1'b1;
        p.idx   = BIT_W'(i);
      end
    end
    return p;
  endfunction

  function automatic word_pick_t pick_word(input logic [NUM_WORDS-1:0] v);
    word_pick_t p;
    p = '0;
    for (int i = NUM_WORDS - 1; i >= 0; i--) begin
      if (!v[i]) begin
        p.found = 1'b1;
        p.idx   = WORD_IDX_W'(i);
      end
    end
    return p;
  endfunction

  // Rooms past the last one count as taken.
  function automatic logic [WORD_W-1:0] row_pad(input logic [WORD_IDX_W-1:0] row);
    logic [WORD_W-1:0] pad;
    pad = '0;
    for (int b = 0; b < WORD_W; b++) begin
      if ((int'(row) * WORD_W + b) >= NUM_ROOMS) pad[b] = 1'b1;
    end
    return pad;
  endfunction

  logic [WORD_W-1:0]     bitmap_r [NUM_WORDS];
  logic [NUM_WORDS-1:0]  row_full_r;
  logic [ROOM_W-1:0]     room_tbl [NUM_CUSTOMERS];

  logic [OP_W-1:0]       op_r;
  logic [CUST_IDX_W-1:0] cid_r;
  logic [WORD_IDX_W-1:0] word_r;
  logic                  any_free_r;
  logic [ROOM_W-1:0]     rd_data_r;
  logic [COUNT_W-1:0]    occ_r, occ_nxt;
  logic [COUNT_W-1:0]    peak_r, peak_nxt;
  logic [ROOM_W-1:0]     room_out_r;
  logic                  no_room_out_r;
  logic [COUNT_W-1:0]    cur_out_r;
  logic [COUNT_W-1:0]    peak_out_r;

  word_pick_t            word_pick;
  bit_pick_t             bit_pick;
  logic                  is_depart;
  logic                  held_ok;
  logic [IDX_W-1:0]      dep_idx;
  logic [WORD_IDX_W-1:0] row_sel;
  logic [BIT_W-1:0]      bit_sel;
  logic [WORD_W-1:0]     row_data;
  logic [WORD_W-1:0]     row_pad_sel;
  logic [WORD_W-1:0]     bit_mask;
  logic [WORD_W-1:0]     row_new;
  logic                  row_full_new;
  logic                  change;
  logic [ROOM_W-1:0]     room_val;
  logic [ROOM_W-1:0]     tbl_wr;
  logic [CUST_IDX_W-1:0] cid_idx;

  assign cid_idx   = in_customer_id[CUST_IDX_W-1:0];
  assign word_pick = pick_word(row_full_r);

  assign is_depart = (op_r == OP_DEPART);
  assign held_ok   = (rd_data_r != '0) && (rd_data_r <= ROOM_W'(NUM_ROOMS));
  assign dep_idx   = IDX_W'(rd_data_r - ROOM_W'(1));

  assign row_sel     = is_depart ? dep_idx[IDX_W-1:BIT_W] : word_r;
  assign row_data    = bitmap_r[row_sel];
  assign row_pad_sel = row_pad(row_sel);
  assign bit_pick    = pick_bit(row_data | row_pad_sel);
  assign bit_sel     = is_depart ? dep_idx[BIT_W-1:0] : bit_pick.idx;
  assign bit_mask    = WORD_W'(1) << bit_sel;

  always_comb begin
    if (is_depart) begin
      change       = held_ok && row_data[bit_sel];
      row_new      = row_data & ~bit_mask;
      row_full_new = 1'b0;
      room_val     = change ? rd_data_r : '0;
      tbl_wr       = '0;
      occ_nxt      = change ? occ_r - COUNT_W'(1) : occ_r;
    end else begin
      change       = any_free_r;
      row_new      = row_data | bit_mask;
      row_full_new = &(row_new | row_pad_sel);
      room_val     = change ? ROOM_W'({row_sel, bit_sel}) + ROOM_W'(1) : '0;
      tbl_wr       = room_val;
      occ_nxt      = change ? occ_r + COUNT_W'(1) : occ_r;
    end
    peak_nxt = (occ_nxt > peak_r) ? occ_nxt : peak_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int w = 0; w < NUM_WORDS; w++) bitmap_r[w] <= '0;
      row_full_r <= '0;
      occ_r      <= '0;
      peak_r     <= '0;
    end else if (cmd.apply) begin
      if (change) begin
        bitmap_r[row_sel]   <= row_new;
        row_full_r[row_sel] <= row_full_new;
      end
      occ_r  <= occ_nxt;
      peak_r <= peak_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) room_tbl[cid_r] <= tbl_wr;
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) rd_data_r <= room_tbl[cid_idx];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r       <= in_operation;
      cid_r      <= cid_idx;
      word_r     <= word_pick.idx;
      any_free_r <= word_pick.found;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      room_out_r    <= room_val;
      no_room_out_r <= !is_depart && !any_free_r;
      cur_out_r     <= occ_nxt;
      peak_out_r    <= peak_nxt;
    end
  end

  assign out_room_number   = room_out_r;
  assign out_no_room       = no_room_out_r;
  assign out_current_count = cur_out_r;
  assign out_peak_count    = peak_out_r;

endmodule
`default_nettype wire

### bench/lowest_free_room_allocator_tb.sv
// Self-checking bench for lowest_free_room_allocator: arrive/depart traffic with a
// built-in occupancy predictor, random idling on both channels and one long output hold.
// Depends on lfra_pkg and the lowest_free_room_allocator RTL.
`timescale 1ns / 1ps
module lowest_free_room_allocator_tb;
  import lfra_pkg::*;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [CUST_W-1:0] cid;
  } guest_move_t;

  typedef struct packed {
    logic [ROOM_W-1:0]  room;
    logic               full;
    logic [COUNT_W-1:0] occ;
    logic [COUNT_W-1:0] peak;
  } stay_result_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [OP_W-1:0]     in_operation = OP_ARRIVE;
  logic [CUST_W-1:0]   in_customer_id = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [ROOM_W-1:0]   out_room_number;
  logic                out_no_room;
  logic [COUNT_W-1:0]  out_current_count;
  logic [COUNT_W-1:0]  out_peak_count;

  lowest_free_room_allocator uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_operation      (in_operation),
    .in_customer_id    (in_customer_id),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_room_number   (out_room_number),
    .out_no_room       (out_no_room),
    .out_current_count (out_current_count),
    .out_peak_count    (out_peak_count)
  );

  always #6 clk = ~clk;

  guest_move_t  pending_moves[$];
  stay_result_t expected_stays[$];

  // stimulus bookkeeping
  bit ever_arrived [NUM_CUSTOMERS];
  bit in_house [NUM_CUSTOMERS];
  int ids_seen[$];
  int ids_in_house[$];

  // predictor state
  bit                rooms_taken [NUM_ROOMS];
  logic [ROOM_W-1:0] room_held_by [NUM_CUSTOMERS];
  int                guests_now = 0;
  int                guests_peak = 0;

  int   idle_left = 0;
  int   stall_left = 0;
  int   hold_left = 0;
  bit   hold_done = 1'b0;
  bit   tail_reached = 1'b0;
  int   results_seen = 0;
  int   arrivals_sent = 0;
  int   departures_sent = 0;
  int   turned_away = 0;
  int   peak_reported = 0;
  int   mismatches = 0;
  logic [15:0] beat = '0;
  wire  calm = (beat[8:7] == 2'b11);

  function automatic stay_result_t assign_or_free_room(guest_move_t mv);
    stay_result_t r;
    int slot;
    int held;
    int idx;
    r = '0;
    idx = mv.cid % NUM_CUSTOMERS;
    if (mv.op == OP_ARRIVE) begin
      slot = NUM_ROOMS;
      for (int s = NUM_ROOMS - 1; s >= 0; s--)
        if (!rooms_taken[s]) slot = s;
      if (slot < NUM_ROOMS) begin
        rooms_taken[slot] = 1'b1;
        r.room = ROOM_W'(slot + 1);
        guests_now++;
        if (guests_now > guests_peak) guests_peak = guests_now;
      end else begin
        r.full = 1'b1;
      end
      room_held_by[idx] = r.room;
    end else begin
      held = room_held_by[idx];
      if (held >= 1 && held <= NUM_ROOMS && rooms_taken[held - 1]) begin
        rooms_taken[held - 1] = 1'b0;
        r.room = ROOM_W'(held);
        if (guests_now > 0) guests_now--;
      end
      room_held_by[idx] = '0;
    end
    r.occ  = COUNT_W'(guests_now);
    r.peak = COUNT_W'(guests_peak);
    return r;
  endfunction

  task automatic queue_arrival(input int id);
    guest_move_t mv;
    mv.op  = OP_ARRIVE;
    mv.cid = CUST_W'(id);
    pending_moves.insert(pending_moves.size(), mv);
    if (!ever_arrived[id]) begin
      ever_arrived[id] = 1'b1;
      ids_seen.insert(ids_seen.size(), id);
    end
    in_house[id] = 1'b1;
    ids_in_house.insert(ids_in_house.size(), id);
  endtask

  task automatic queue_departure(input int id);
    guest_move_t mv;
    mv.op  = OP_DEPART;
    mv.cid = CUST_W'(id);
    pending_moves.insert(pending_moves.size(), mv);
    in_house[id] = 1'b0;
    for (int k = ids_in_house.size() - 1; k >= 0; k--)
      if (ids_in_house[k] == id) ids_in_house.delete(k);
  endtask

  task automatic queue_random_move(input int arrive_pct);
    int id;
    if (ids_seen.size() == 0 || $urandom_range(0, 99) < arrive_pct) begin
      if (ids_in_house.size() > 0 && $urandom_range(0, 19) == 0) begin
        queue_arrival(ids_in_house[$urandom_range(0, ids_in_house.size() - 1)]);
      end else begin
        do id = $urandom_range(0, NUM_CUSTOMERS - 1); while (in_house[id]);
        queue_arrival(id);
      end
    end else if (ids_in_house.size() > 0 && $urandom_range(0, 99) < 85) begin
      queue_departure(ids_in_house[$urandom_range(0, ids_in_house.size() - 1)]);
    end else begin
      queue_departure(ids_seen[$urandom_range(0, ids_seen.size() - 1)]);
    end
  endtask

  task automatic check_field(input string what, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $display("%0t ns: %s expected %0d, got %0d", $time, what, want, got);
      mismatches++;
    end
  endtask

  initial begin
    queue_arrival(0);
    queue_arrival(1023);
    queue_arrival(512);
    queue_departure(1023);
    queue_arrival(5);
    queue_arrival(0);
    queue_departure(0);
    queue_departure(0);
    queue_departure(1023);
    queue_arrival(682);
    queue_arrival(341);
    queue_departure(5);
    queue_departure(512);
    queue_arrival(1);
    queue_departure(682);
    queue_departure(341);
    queue_arrival(1022);
    queue_departure(1);
    // fill to capacity, hover at full, drain, then mixed traffic
    for (int i = 0; i < 780; i++) begin
      if (i < 340)      queue_random_move(92);
      else if (i < 480) queue_random_move(50);
      else if (i < 680) queue_random_move(12);
      else              queue_random_move(50);
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_moves.size() > 0 || in_valid) @(posedge clk);
    while (expected_stays.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Checked %0d results: %0d arrivals, %0d departures.",
             results_seen, arrivals_sent, departures_sent);
    $display("Arrivals turned away when full: %0d, highest peak count: %0d.",
             turned_away, peak_reported);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  always @(posedge clk) beat <= beat + 1'b1;

  always @(posedge clk) begin : drive_moves
    guest_move_t nxt;
    if (!rst_n) begin
      in_valid  <= 1'b0;
      idle_left <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_stays.insert(expected_stays.size(),
                              assign_or_free_room('{in_operation, in_customer_id}));
        if (in_operation == OP_ARRIVE) arrivals_sent++;
        else departures_sent++;
      end
      if (pending_moves.size() < 80) tail_reached <= 1'b1;
      if (!in_valid || !in_stall) begin
        if (idle_left > 0) begin
          in_valid  <= 1'b0;
          idle_left <= idle_left - 1;
        end else if (pending_moves.size() == 0) begin
          in_valid <= 1'b0;
        end else if (!tail_reached && !calm && $urandom_range(0, 99) < 20) begin
          in_valid  <= 1'b0;
          idle_left <= $urandom_range(0, 9);
        end else begin
          nxt = pending_moves.pop_front();
          in_valid       <= 1'b1;
          in_operation   <= nxt.op;
          in_customer_id <= nxt.cid;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
      hold_left  <= 0;
      hold_done  <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_seen >= 150) begin
      out_stall <= 1'b1;
      hold_left <= 400;
      hold_done <= 1'b1;
    end else if (tail_reached || calm) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 99) < 15) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 9);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : check_stays
    stay_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen <= results_seen + 1;
      if (out_no_room === 1'b1) turned_away++;
      if (out_peak_count > peak_reported) peak_reported = out_peak_count;
      if (expected_stays.size() == 0) begin
        $display("%0t ns: unexpected transaction, expected none, got room %0d",
                 $time, out_room_number);
        mismatches++;
      end else begin
        want = expected_stays.pop_front();
        check_field("room_number", want.room, out_room_number);
        check_field("no_room", want.full, out_no_room);
        check_field("current_count", want.occ, out_current_count);
        check_field("peak_count", want.peak, out_peak_count);
      end
    end
  end

endmodule
